// ===== design/atan2r_pkg.sv =====
package atan2r_pkg;

    localparam int FRAC_BITS  = 20;
    localparam int RATIO_BITS = 16;
    localparam int RATIO_QW   = RATIO_BITS + 1;
    localparam int R_W        = FRAC_BITS + 1;
    localparam int Q_W        = 24;
    localparam int ANGLE_W    = 16;

    typedef logic signed [Q_W-1:0] t_q20;
    typedef logic [R_W-1:0]        t_ur;

    typedef struct packed {
        logic yneg;
        logic xneg;
        logic oct;
        logic zero;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

    localparam t_q20 C2_Q20      = 24'sd1048548;
    localparam t_q20 C3_Q20      = 24'sd154602;
    localparam t_q20 C4_Q20      = 24'sd325039;
    localparam t_q20 C5_Q20      = 24'sd52745;
    localparam t_q20 C6_Q20      = 24'sd154250;
    localparam t_q20 C7_Q20      = 24'sd675770;
    localparam t_q20 ONE_Q20     = 24'sd1048576;
    localparam t_q20 PI_Q20      = 24'sd3294199;
    localparam t_q20 HALF_PI_Q20 = 24'sd1647099;

    // Q20 x Q20 -> Q20, round to nearest, ties up
    function automatic t_q20 q20_mul(input t_q20 a, input t_ur r);
        logic signed [Q_W+R_W:0] p;
        p = a * $signed({1'b0, r});
        p = p + $signed((Q_W+R_W+1)'(1) <<< (FRAC_BITS - 1));
        return p[FRAC_BITS+Q_W-1:FRAC_BITS];
    endfunction

endpackage

// ===== design/atan2r_in_if.sv =====
interface atan2r_in_if #(
    parameter int W = 16
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] y_value;
    logic signed [W-1:0] x_value;

    modport source(output valid, output y_value, output x_value, input ready);
    modport sink(input valid, input y_value, input x_value, output ready);
endinterface

// ===== design/atan2r_out_if.sv =====
interface atan2r_out_if ();
    logic               valid;
    logic               ready;
    logic signed [15:0] angle;

    modport source(output valid, output angle, input ready);
    modport sink(input valid, input angle, output ready);
endinterface

// ===== design/atan2r_front.sv =====
module atan2r_front
    import atan2r_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [W-1:0]        i_y,
    input  logic [W-1:0]        i_x,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [W-1:0]        o_rem,
    output logic [RATIO_QW-1:0] o_low,
    output logic [W-1:0]        o_divisor,
    output t_flags              o_flags
);
    logic         r_valid;
    logic [W-1:0] r_rem;
    logic [RATIO_QW-1:0] r_low;
    logic [W-1:0] r_div;
    t_flags       r_flags;

    logic         w_en;
    logic [W-1:0] w_ay, w_ax, w_mx, w_mn;
    t_flags       n_flags;

    assign w_en = !r_valid || i_ready;

    always_comb begin
        n_flags.yneg = i_y[W-1];
        n_flags.xneg = i_x[W-1];
        w_ay = n_flags.yneg ? (~i_y + W'(1)) : i_y;
        w_ax = n_flags.xneg ? (~i_x + W'(1)) : i_x;
        n_flags.oct = w_ay > w_ax;
        w_mx = n_flags.oct ? w_ay : w_ax;
        w_mn = n_flags.oct ? w_ax : w_ay;
        n_flags.zero = (w_mx == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem   <= w_mn >> 1;
            r_low   <= {w_mn[0], {RATIO_BITS{1'b0}}};
            r_div   <= w_mx;
            r_flags <= n_flags;
        end
    end

    assign o_ready   = w_en;
    assign o_valid   = r_valid;
    assign o_rem     = r_rem;
    assign o_low     = r_low;
    assign o_divisor = r_div;
    assign o_flags   = r_flags;
endmodule

// ===== design/atan2r_div.sv =====
module atan2r_div #(
    parameter int DW = 16,
    parameter int QW = 17,
    parameter int SW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [DW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);
    logic [QW-1:0] r_v;
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_low  [QW];
    logic [DW-1:0] r_div  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [SW-1:0] r_side [QW];

    logic [QW:0]   w_en;
    logic [QW-1:0] w_v;
    logic [DW-1:0] w_rem  [QW];
    logic [QW-1:0] w_low  [QW];
    logic [DW-1:0] w_div  [QW];
    logic [QW-1:0] w_q    [QW];
    logic [SW-1:0] w_side [QW];
    logic [DW-1:0] n_rem  [QW];
    logic [QW-1:0] n_q    [QW];
    logic [DW:0]   w_trial[QW];
    logic [QW-1:0] w_take;

    always_comb begin
        w_en[QW] = i_ready;
        for (int k = QW - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_comb begin
        w_v[0]    = i_valid;
        w_rem[0]  = i_rem;
        w_low[0]  = i_low;
        w_div[0]  = i_divisor;
        w_q[0]    = '0;
        w_side[0] = i_side;
        for (int k = 1; k < QW; k++) begin
            w_v[k]    = r_v[k-1];
            w_rem[k]  = r_rem[k-1];
            w_low[k]  = r_low[k-1];
            w_div[k]  = r_div[k-1];
            w_q[k]    = r_q[k-1];
            w_side[k] = r_side[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            w_trial[k] = {w_rem[k], w_low[k][QW-1]};
            w_take[k]  = w_trial[k] >= {1'b0, w_div[k]};
            n_rem[k]   = w_take[k] ? DW'(w_trial[k] - {1'b0, w_div[k]})
                                   : w_trial[k][DW-1:0];
            n_q[k]     = {w_q[k][QW-2:0], w_take[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < QW; k++) begin
                if (w_en[k]) r_v[k] <= w_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (w_en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= w_low[k] << 1;
                r_div[k]  <= w_div[k];
                r_q[k]    <= n_q[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_side  = r_side[QW-1];
endmodule

// ===== design/atan2r_poly.sv =====
module atan2r_poly
    import atan2r_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [RATIO_QW-1:0] i_ratio,
    input  t_flags              i_flags,
    output logic                o_valid,
    input  logic                i_ready,
    output t_ur                 o_rem,
    output t_ur                 o_low,
    output t_ur                 o_den,
    output t_flags              o_flags
);
    localparam int NS = 5;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_en;
    t_flags        r_f [NS];

    t_ur  r1_r, r2_r, r3_r;
    t_q20 r1_t, r2_t, r3_t;
    t_q20 r1_d, r2_d, r3_d;
    t_ur  r4_num, r4_den;
    t_ur  r5_rem, r5_low, r5_den;

    t_ur                  w_r;
    t_q20                 w_neg;
    logic [2*R_W-1:0]     w_dvd;

    always_comb begin
        w_en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_r   = i_flags.zero ? '0 : {i_ratio, {(FRAC_BITS - RATIO_BITS){1'b0}}};
    assign w_neg = -q20_mul(r3_t, r3_r);
    assign w_dvd = {r4_num, {FRAC_BITS{1'b0}}} + (2*R_W)'(r4_den >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_r   <= w_r;
            r1_t   <= q20_mul(C5_Q20, w_r) - C4_Q20;
            r1_d   <= q20_mul(C7_Q20, w_r) + C6_Q20;
            r_f[0] <= i_flags;
        end
        if (w_en[1]) begin
            r2_r   <= r1_r;
            r2_t   <= q20_mul(r1_t, r1_r) - C3_Q20;
            r2_d   <= q20_mul(r1_d, r1_r) + ONE_Q20;
            r_f[1] <= r_f[0];
        end
        if (w_en[2]) begin
            r3_r   <= r2_r;
            r3_t   <= q20_mul(r2_t, r2_r) - C2_Q20;
            r3_d   <= r2_d;
            r_f[2] <= r_f[1];
        end
        if (w_en[3]) begin
            r4_num <= w_neg[Q_W-1] ? '0 : w_neg[R_W-1:0];
            r4_den <= r3_d[R_W-1:0];
            r_f[3] <= r_f[2];
        end
        if (w_en[4]) begin
            r5_rem <= w_dvd[2*R_W-1:R_W];
            r5_low <= w_dvd[R_W-1:0];
            r5_den <= r4_den;
            r_f[4] <= r_f[3];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NS-1];
    assign o_rem   = r5_rem;
    assign o_low   = r5_low;
    assign o_den   = r5_den;
    assign o_flags = r_f[NS-1];
endmodule

// ===== design/atan2r_fold.sv =====
module atan2r_fold
    import atan2r_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  t_ur                       i_quot,
    input  t_flags                    i_flags,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [ANGLE_W-1:0] o_angle
);
    logic [1:0]  r_v;
    logic [2:0]  w_en;
    logic [R_W:0] r_res;
    logic        r_yneg;
    logic signed [ANGLE_W-1:0] r_angle;

    t_q20              w_s;
    logic [R_W+1:0]    w_sum;
    logic [ANGLE_W-1:0] w_mag;

    assign w_en[2] = i_ready;
    assign w_en[1] = !r_v[1] || w_en[2];
    assign w_en[0] = !r_v[0] || w_en[1];

    always_comb begin
        w_s = $signed({{(Q_W - R_W){1'b0}}, i_quot});
        if (i_flags.oct)  w_s = HALF_PI_Q20 - w_s;
        if (i_flags.xneg) w_s = PI_Q20 - w_s;
        if (w_s < 0)      w_s = '0;
        w_sum = {1'b0, r_res} + (R_W+2)'(64);
        w_mag = w_sum[R_W+1:7];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            if (w_en[1]) r_v[1] <= r_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_res  <= w_s[R_W:0];
            r_yneg <= i_flags.yneg;
        end
        if (w_en[1]) begin
            r_angle <= r_yneg ? $signed(ANGLE_W'(0) - w_mag) : $signed(w_mag);
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[1];
    assign o_angle = r_angle;
endmodule

// ===== design/arctangent2_rational_approx.sv =====
// Stages from an accepted item to its result: 1 operand stage, 17 ratio
// divider stages, 5 polynomial stages, 21 quotient divider stages, 2 octant
// fold stages. Throughput: one item per cycle unless the output stalls.
// Each stage advances on its own when empty, so bubbles collapse under stall.
// Reset: synchronous, active low; clears all stage valid bits.
module arctangent2_rational_approx
    import atan2r_pkg::*;
#(
    parameter int INPUT_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    atan2r_in_if.sink     i_sample,
    atan2r_out_if.source  o_result
);
    logic                  f_valid, f_ready;
    logic [INPUT_BITS-1:0] f_rem, f_div;
    logic [RATIO_QW-1:0]   f_low;
    t_flags                f_flags;

    logic                  d1_valid, d1_ready;
    logic [RATIO_QW-1:0]   d1_quot;
    logic [FLAGS_W-1:0]    d1_side;

    logic                  p_valid, p_ready;
    t_ur                   p_rem, p_low, p_den;
    t_flags                p_flags;

    logic                  d2_valid, d2_ready;
    t_ur                   d2_quot;
    logic [FLAGS_W-1:0]    d2_side;

    atan2r_front #(.W(INPUT_BITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_sample.valid),
        .o_ready   (i_sample.ready),
        .i_y       (i_sample.y_value),
        .i_x       (i_sample.x_value),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_rem     (f_rem),
        .o_low     (f_low),
        .o_divisor (f_div),
        .o_flags   (f_flags)
    );

    atan2r_div #(.DW(INPUT_BITS), .QW(RATIO_QW), .SW(FLAGS_W)) u_ratio_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (f_valid),
        .o_ready   (f_ready),
        .i_rem     (f_rem),
        .i_low     (f_low),
        .i_divisor (f_div),
        .i_side    (f_flags),
        .o_valid   (d1_valid),
        .i_ready   (d1_ready),
        .o_quot    (d1_quot),
        .o_side    (d1_side)
    );

    atan2r_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d1_valid),
        .o_ready (d1_ready),
        .i_ratio (d1_quot),
        .i_flags (t_flags'(d1_side)),
        .o_valid (p_valid),
        .i_ready (p_ready),
        .o_rem   (p_rem),
        .o_low   (p_low),
        .o_den   (p_den),
        .o_flags (p_flags)
    );

    atan2r_div #(.DW(R_W), .QW(R_W), .SW(FLAGS_W)) u_quot_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (p_valid),
        .o_ready   (p_ready),
        .i_rem     (p_rem),
        .i_low     (p_low),
        .i_divisor (p_den),
        .i_side    (p_flags),
        .o_valid   (d2_valid),
        .i_ready   (d2_ready),
        .o_quot    (d2_quot),
        .o_side    (d2_side)
    );

    atan2r_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d2_valid),
        .o_ready (d2_ready),
        .i_quot  (d2_quot),
        .i_flags (t_flags'(d2_side)),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_angle (o_result.angle)
    );
endmodule

// ===== design/atan2r_checker.sv =====
module atan2r_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [15:0] i_angle
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_angle))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_angle >= -16'sd25736) && (i_angle <= 16'sd25736))
        else $error("angle outside -pi..pi");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");
endmodule

bind arctangent2_rational_approx atan2r_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_angle     (o_result.angle)
);

// ===== tb/arctangent2_rational_approx_tb.sv =====
`timescale 1ns / 1ps

module arctangent2_rational_approx_tb
    import atan2r_pkg::*;
();

    localparam int LATENCY = 46;

    typedef struct {
        logic signed [15:0] y_value;
        logic signed [15:0] x_value;
    } t_sample;

    logic i_clk;
    logic i_rst_n;

    atan2r_in_if #(.W(16)) sample_if ();
    atan2r_out_if          result_if ();

    arctangent2_rational_approx #(.INPUT_BITS(16)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if.sink),
        .o_result (result_if.source)
    );

    t_sample            pending_samples[$];
    logic signed [15:0] expected_angles[$];

    int  mismatch_count;
    int  unexpected_count;
    int  sent_count;
    int  received_count;
    int  send_gap;
    int  recv_gap;
    int  hold_off;
    bit  quiet_phase;
    bit  pause_sender;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint round_mul(longint a, longint b);
        longint p;
        p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
        return p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [15:0] predict_angle(logic signed [15:0] yv,
                                                         logic signed [15:0] xv);
        longint ay;
        longint ax;
        longint mx;
        longint mn;
        longint ratio;
        longint num;
        longint den;
        longint res;
        longint mag;
        ay = (yv < 0) ? -longint'(yv) : longint'(yv);
        ax = (xv < 0) ? -longint'(xv) : longint'(xv);
        mx = (ay > ax) ? ay : ax;
        mn = (ay > ax) ? ax : ay;
        ratio = (mx != 0) ? (mn <<< 16) / mx : 0;
        ratio = ratio <<< (FRAC_BITS - 16);
        num = round_mul(longint'(C5_Q20), ratio) - longint'(C4_Q20);
        num = round_mul(num, ratio) - longint'(C3_Q20);
        num = round_mul(num, ratio) - longint'(C2_Q20);
        num = round_mul(num, ratio);
        num = -num;
        if (num < 0) begin
            num = 0;
        end
        den = round_mul(round_mul(longint'(C7_Q20), ratio) + longint'(C6_Q20), ratio)
              + longint'(ONE_Q20);
        res = ((num <<< FRAC_BITS) + (den >>> 1)) / den;
        if (ay > ax) begin
            res = longint'(HALF_PI_Q20) - res;
        end
        if (xv < 0) begin
            res = longint'(PI_Q20) - res;
        end
        if (res < 0) begin
            res = 0;
        end
        mag = (res + 64) >>> 7;
        return (yv < 0) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic queue_sample(logic signed [15:0] yv, logic signed [15:0] xv);
        t_sample s;
        s.y_value = yv;
        s.x_value = xv;
        pending_samples.push_back(s);
    endtask

    function automatic logic signed [15:0] random_axis();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 4) - 2);
            1: return 16'sh8000 + 16'($urandom_range(0, 3));
            2: return 16'sh7fff - 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sample_if.valid   <= 1'b0;
            sample_if.y_value <= '0;
            sample_if.x_value <= '0;
            send_gap          <= 0;
        end else if (!sample_if.valid || sample_if.ready) begin
            if (sample_if.valid) begin
                expected_angles.push_back(predict_angle(sample_if.y_value,
                                                        sample_if.x_value));
                sent_count <= sent_count + 1;
            end
            if (send_gap > 0) begin
                send_gap        <= send_gap - 1;
                sample_if.valid <= 1'b0;
            end else if (pending_samples.size() > 0 && !pause_sender) begin
                sample_if.valid   <= 1'b1;
                sample_if.y_value <= pending_samples[0].y_value;
                sample_if.x_value <= pending_samples[0].x_value;
                void'(pending_samples.pop_front());
                if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 16);
                end
            end else begin
                sample_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            recv_gap        <= 0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                received_count <= received_count + 1;
                if (expected_angles.size() == 0) begin
                    unexpected_count <= unexpected_count + 1;
                    if (mismatch_count + unexpected_count < 10) begin
                        $display("unexpected result angle=%0d", result_if.angle);
                    end
                end else begin
                    if (result_if.angle !== expected_angles[0]) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count + unexpected_count < 10) begin
                            $display("angle mismatch: expected %0d actual %0d",
                                     expected_angles[0], result_if.angle);
                        end
                    end
                    void'(expected_angles.pop_front());
                end
            end
            if (hold_off > 0) begin
                result_if.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap        <= recv_gap - 1;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
                if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                    recv_gap <= $urandom_range(1, 16);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
        end
    end

    initial begin
        int i;
        mismatch_count   = 0;
        unexpected_count = 0;
        sent_count       = 0;
        received_count   = 0;
        hold_off         = 0;
        quiet_phase      = 1'b0;
        pause_sender     = 1'b0;
        sample_if.valid   = 1'b0;
        sample_if.y_value = '0;
        sample_if.x_value = '0;
        result_if.ready   = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_sample(16'sd0, 16'sd0);
        queue_sample(16'sd0, -16'sd1);
        queue_sample(16'sd0, 16'sh8000);
        queue_sample(16'sd0, 16'sd1);
        queue_sample(16'sd1, 16'sd0);
        queue_sample(-16'sd1, 16'sd0);
        queue_sample(16'sh7fff, 16'sh7fff);
        queue_sample(16'sh8000, 16'sh8000);
        queue_sample(16'sh7fff, 16'sh8000);
        queue_sample(16'sh8000, 16'sh7fff);
        queue_sample(-16'sd5, 16'sd5);
        queue_sample(16'sd5, -16'sd5);
        queue_sample(16'sh8000, 16'sd0);
        queue_sample(16'sh7fff, 16'sd1);
        queue_sample(16'sd1, 16'sh7fff);
        queue_sample(-16'sd1, 16'sh8000);
        queue_sample(16'sh8000, -16'sd1);
        queue_sample(16'sd100, -16'sd99);
        queue_sample(-16'sd99, -16'sd100);
        queue_sample(16'shffff, 16'shffff);
        for (i = 0; i < 120; i++) begin
            queue_sample(random_axis(), random_axis());
        end

        wait (pending_samples.size() == 0);
        hold_off = 200;
        for (i = 0; i < 120; i++) begin
            queue_sample(random_axis(), random_axis());
        end
        wait (pending_samples.size() == 0);
        @(posedge i_clk);
        pause_sender = 1'b1;
        wait (!sample_if.valid && expected_angles.size() == 0);
        repeat (20) @(posedge i_clk);
        pause_sender = 1'b0;

        for (i = 0; i < 160; i++) begin
            queue_sample(random_axis(), random_axis());
        end
        wait (pending_samples.size() == 0);
        quiet_phase = 1'b1;
        for (i = 0; i < 100; i++) begin
            queue_sample(random_axis(), random_axis());
        end
        wait (pending_samples.size() == 0 && !sample_if.valid);
        wait (expected_angles.size() == 0);
        repeat (LATENCY * 2) @(posedge i_clk);

        $display("covered %0d sample pairs (all quadrants, axes, diagonals, extremes)",
                 sent_count);
        $display("received %0d angles with random stalls and one long output hold-off",
                 received_count);
        if (mismatch_count == 0 && unexpected_count == 0 && expected_angles.size() == 0) begin
            $display("arctangent2_rational_approx regression: pass");
        end else begin
            $display("arctangent2_rational_approx regression: fail");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("arctangent2_rational_approx regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/atan2r_pkg.sv
design/atan2r_in_if.sv
design/atan2r_out_if.sv
design/atan2r_front.sv
design/atan2r_div.sv
design/atan2r_poly.sv
design/atan2r_fold.sv
design/arctangent2_rational_approx.sv
design/atan2r_checker.sv
tb/arctangent2_rational_approx_tb.sv
